### hw/rtl/tsl_pkg.sv
package tsl_pkg;

    // Position counter width; positions wrap modulo 2**POS_BITS.
    localparam int POS_BITS = 16;
    localparam int LEN_BITS = 16;
    localparam int OUT_POS_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Depth of the word queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Character codes used by the classifier.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    typedef enum logic [4:0] {
        KIND_ILLEGAL   = 5'd0,
        KIND_EOF       = 5'd1,
        KIND_IDENT     = 5'd2,
        KIND_INT       = 5'd3,
        KIND_STRING    = 5'd4,
        KIND_ASSIGN    = 5'd5,
        KIND_PLUS      = 5'd6,
        KIND_MINUS     = 5'd7,
        KIND_BANG      = 5'd8,
        KIND_ASTERISK  = 5'd9,
        KIND_SLASH     = 5'd10,
        KIND_LT        = 5'd11,
        KIND_GT        = 5'd12,
        KIND_EQ        = 5'd13,
        KIND_NOT_EQ    = 5'd14,
        KIND_COMMA     = 5'd15,
        KIND_SEMICOLON = 5'd16,
        KIND_COLON     = 5'd17,
        KIND_LPAREN    = 5'd18,
        KIND_RPAREN    = 5'd19,
        KIND_LBRACE    = 5'd20,
        KIND_RBRACE    = 5'd21,
        KIND_LBRACKET  = 5'd22,
        KIND_RBRACKET  = 5'd23
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_STRING,
        MODE_PEND_EQ,
        MODE_PEND_BANG
    } mode_t;

    // One finished token.
    typedef struct packed {
        kind_t                   kind;
        logic [OUT_POS_BITS-1:0] start_pos;
        logic [LEN_BITS-1:0]     text_len;
    } tok_t;

    // All tokens caused by one input byte: one or two.
    typedef struct packed {
        logic two;
        tok_t tok0;
        tok_t tok1;
    } bundle_t;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        unique case (c)
            CH_PLUS:      single_kind = KIND_PLUS;
            CH_MINUS:     single_kind = KIND_MINUS;
            CH_STAR:      single_kind = KIND_ASTERISK;
            CH_SLASH:     single_kind = KIND_SLASH;
            CH_LT:        single_kind = KIND_LT;
            CH_GT:        single_kind = KIND_GT;
            CH_COMMA:     single_kind = KIND_COMMA;
            CH_SEMICOLON: single_kind = KIND_SEMICOLON;
            CH_COLON:     single_kind = KIND_COLON;
            CH_LPAREN:    single_kind = KIND_LPAREN;
            CH_RPAREN:    single_kind = KIND_RPAREN;
            CH_LBRACE:    single_kind = KIND_LBRACE;
            CH_RBRACE:    single_kind = KIND_RBRACE;
            CH_LBRACKET:  single_kind = KIND_LBRACKET;
            CH_RBRACKET:  single_kind = KIND_RBRACKET;
            default:      single_kind = KIND_ILLEGAL;
        endcase
    endfunction

endpackage

### hw/rtl/tsl_front.sv
module tsl_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [7:0]        in_ch,
    input  logic              in_is_end,
    output logic              push,
    output tsl_pkg::bundle_t  push_bundle
);

    tsl_pkg::mode_t                  mode_reg, mode_next;
    logic [tsl_pkg::POS_BITS-1:0]    start_reg, start_next;
    logic [tsl_pkg::LEN_BITS-1:0]    len_reg, len_next;
    logic [tsl_pkg::POS_BITS-1:0]    pos_reg, pos_next;

    logic [tsl_pkg::POS_BITS-1:0]    pos_inc;
    logic [tsl_pkg::LEN_BITS-1:0]    len_grow;
    logic                            flush_valid;
    tsl_pkg::tok_t                   flush_tok;
    logic                            restart;
    logic                            second_valid;
    tsl_pkg::tok_t                   second_tok;

    assign pos_inc  = pos_reg + {{(tsl_pkg::POS_BITS-1){1'b0}}, 1'b1};
    assign len_grow = (len_reg == tsl_pkg::LEN_MAX) ? len_reg
                                                    : len_reg + {{(tsl_pkg::LEN_BITS-1){1'b0}}, 1'b1};

    // Lexer state update and token generation for one byte.
    always_comb begin
        mode_next    = mode_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        pos_next     = pos_inc;
        flush_valid  = 1'b0;
        flush_tok.kind      = tsl_pkg::KIND_ILLEGAL;
        flush_tok.start_pos = tsl_pkg::OUT_POS_BITS'(start_reg);
        flush_tok.text_len  = len_reg;
        restart      = 1'b0;
        second_valid = 1'b0;
        second_tok.kind      = tsl_pkg::KIND_EOF;
        second_tok.start_pos = tsl_pkg::OUT_POS_BITS'(pos_reg);
        second_tok.text_len  = '0;

        if (in_is_end) begin
            // Flush the pending token, then EOF, then back to reset state.
            unique case (mode_reg)
                tsl_pkg::MODE_IDENT: begin
                    flush_valid = 1'b1;
                    flush_tok.kind = tsl_pkg::KIND_IDENT;
                end
                tsl_pkg::MODE_INT: begin
                    flush_valid = 1'b1;
                    flush_tok.kind = tsl_pkg::KIND_INT;
                end
                tsl_pkg::MODE_STRING: begin
                    flush_valid = 1'b1;
                    flush_tok.kind = tsl_pkg::KIND_STRING;
                end
                tsl_pkg::MODE_PEND_EQ: begin
                    flush_valid = 1'b1;
                    flush_tok.kind = tsl_pkg::KIND_ASSIGN;
                    flush_tok.text_len = tsl_pkg::LEN_BITS'(1);
                end
                tsl_pkg::MODE_PEND_BANG: begin
                    flush_valid = 1'b1;
                    flush_tok.kind = tsl_pkg::KIND_BANG;
                    flush_tok.text_len = tsl_pkg::LEN_BITS'(1);
                end
                default: begin
                end
            endcase
            second_valid = 1'b1;
            mode_next  = tsl_pkg::MODE_IDLE;
            start_next = '0;
            len_next   = '0;
            pos_next   = '0;
        end else begin
            // Continue or close the pending token.
            unique case (mode_reg)
                tsl_pkg::MODE_IDENT: begin
                    if (tsl_pkg::is_alpha(in_ch)) begin
                        len_next = len_grow;
                    end else begin
                        flush_valid = 1'b1;
                        flush_tok.kind = tsl_pkg::KIND_IDENT;
                        restart = 1'b1;
                    end
                end
                tsl_pkg::MODE_INT: begin
                    if (tsl_pkg::is_digit(in_ch)) begin
                        len_next = len_grow;
                    end else begin
                        flush_valid = 1'b1;
                        flush_tok.kind = tsl_pkg::KIND_INT;
                        restart = 1'b1;
                    end
                end
                tsl_pkg::MODE_STRING: begin
                    if (in_ch == tsl_pkg::CH_QUOTE) begin
                        flush_valid = 1'b1;
                        flush_tok.kind = tsl_pkg::KIND_STRING;
                        mode_next = tsl_pkg::MODE_IDLE;
                    end else begin
                        len_next = len_grow;
                    end
                end
                tsl_pkg::MODE_PEND_EQ, tsl_pkg::MODE_PEND_BANG: begin
                    flush_valid = 1'b1;
                    if (in_ch == tsl_pkg::CH_EQUAL) begin
                        flush_tok.kind = (mode_reg == tsl_pkg::MODE_PEND_EQ)
                                       ? tsl_pkg::KIND_EQ : tsl_pkg::KIND_NOT_EQ;
                        flush_tok.text_len = tsl_pkg::LEN_BITS'(2);
                        mode_next = tsl_pkg::MODE_IDLE;
                    end else begin
                        flush_tok.kind = (mode_reg == tsl_pkg::MODE_PEND_EQ)
                                       ? tsl_pkg::KIND_ASSIGN : tsl_pkg::KIND_BANG;
                        flush_tok.text_len = tsl_pkg::LEN_BITS'(1);
                        restart = 1'b1;
                    end
                end
                default: begin
                    restart = 1'b1;
                end
            endcase

            // Lex the byte afresh when no token holds it.
            if (restart) begin
                mode_next = tsl_pkg::MODE_IDLE;
                priority if (tsl_pkg::is_space(in_ch)) begin
                    mode_next = tsl_pkg::MODE_IDLE;
                end else if (tsl_pkg::is_alpha(in_ch)) begin
                    mode_next  = tsl_pkg::MODE_IDENT;
                    start_next = pos_reg;
                    len_next   = tsl_pkg::LEN_BITS'(1);
                end else if (tsl_pkg::is_digit(in_ch)) begin
                    mode_next  = tsl_pkg::MODE_INT;
                    start_next = pos_reg;
                    len_next   = tsl_pkg::LEN_BITS'(1);
                end else if (in_ch == tsl_pkg::CH_QUOTE) begin
                    mode_next  = tsl_pkg::MODE_STRING;
                    start_next = pos_inc;
                    len_next   = '0;
                end else if (in_ch == tsl_pkg::CH_EQUAL) begin
                    mode_next  = tsl_pkg::MODE_PEND_EQ;
                    start_next = pos_reg;
                    len_next   = tsl_pkg::LEN_BITS'(1);
                end else if (in_ch == tsl_pkg::CH_BANG) begin
                    mode_next  = tsl_pkg::MODE_PEND_BANG;
                    start_next = pos_reg;
                    len_next   = tsl_pkg::LEN_BITS'(1);
                end else begin
                    second_valid = 1'b1;
                    second_tok.kind = tsl_pkg::single_kind(in_ch);
                    second_tok.start_pos = tsl_pkg::OUT_POS_BITS'(pos_reg);
                    second_tok.text_len = tsl_pkg::LEN_BITS'(1);
                    start_next = pos_reg;
                    len_next   = tsl_pkg::LEN_BITS'(1);
                end
            end
        end
    end

    // Pack the tokens of this byte into one queue word.
    always_comb begin
        push = in_accept && (flush_valid || second_valid);
        push_bundle.two  = flush_valid && second_valid;
        push_bundle.tok0 = flush_valid ? flush_tok : second_tok;
        push_bundle.tok1 = second_tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= tsl_pkg::MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

### hw/rtl/tsl_fifo.sv
module tsl_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tsl_pkg::bundle_t  push_bundle,
    input  logic              pop,
    output tsl_pkg::bundle_t  head_bundle,
    output logic              empty,
    output logic              full
);

    tsl_pkg::bundle_t              mem_reg [tsl_pkg::FIFO_DEPTH];
    logic [tsl_pkg::PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tsl_pkg::PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tsl_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                          do_push;
    logic                          do_pop;

    assign empty       = (cnt_reg == '0);
    assign full        = (cnt_reg == tsl_pkg::CNT_BITS'(tsl_pkg::FIFO_DEPTH));
    assign head_bundle = mem_reg[rd_ptr_reg];
    assign do_push     = push && !full;
    assign do_pop      = pop && !empty;

    // Pointer and fill count update with explicit wrap.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == tsl_pkg::PTR_BITS'(tsl_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + {{(tsl_pkg::PTR_BITS-1){1'b0}}, 1'b1};
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == tsl_pkg::PTR_BITS'(tsl_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + {{(tsl_pkg::PTR_BITS-1){1'b0}}, 1'b1};
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + {{(tsl_pkg::CNT_BITS-1){1'b0}}, 1'b1};
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - {{(tsl_pkg::CNT_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

### hw/rtl/tsl_back.sv
module tsl_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tsl_pkg::bundle_t                   head_bundle,
    input  logic                               empty,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [4:0]                         m_kind,
    output logic [tsl_pkg::OUT_POS_BITS-1:0]   m_start_pos,
    output logic [tsl_pkg::LEN_BITS-1:0]       m_text_len,
    output logic                               m_last_of_run
);

    logic                 valid_reg, valid_next;
    logic                 half_reg, half_next;
    tsl_pkg::tok_t        tok_reg, tok_next;
    logic                 last_reg, last_next;
    logic                 load;

    // The output register takes a new word when it is empty or being taken.
    assign load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        half_next  = half_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                if (head_bundle.two && !half_reg) begin
                    // First of two tokens: keep the queue word for the second.
                    tok_next  = head_bundle.tok0;
                    last_next = 1'b0;
                    half_next = 1'b1;
                end else begin
                    tok_next  = half_reg ? head_bundle.tok1 : head_bundle.tok0;
                    last_next = 1'b1;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_kind        = tok_reg.kind;
    assign m_start_pos   = tok_reg.start_pos;
    assign m_text_len    = tok_reg.text_len;
    assign m_last_of_run = last_reg;

endmodule

### hw/rtl/token_stream_lexer.sv
// Channel | Direction | Ports
// --------+-----------+-----------------------------------------------------------------
// input   | in        | s_valid, s_ready, s_ch, s_is_end
// result  | out       | m_valid, m_ready, m_kind, m_start_pos, m_text_len, m_last_of_run
//
// One byte word is accepted per cycle while s_ready is high; results leave one word per
// cycle unless m_ready stalls; a token end plus an operator yields two result words.
// The first result of a byte is queued, then loaded into the output register.
// Synchronous active-low reset clears the lexer mode, position, queue and output valid.
// A stalled result side fills the four-entry queue, after which s_ready drops.
module token_stream_lexer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_ch,
    input  logic                               s_is_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [4:0]                         m_kind,
    output logic [tsl_pkg::OUT_POS_BITS-1:0]   m_start_pos,
    output logic [tsl_pkg::LEN_BITS-1:0]       m_text_len,
    output logic                               m_last_of_run
);

    logic              in_accept;
    logic              push;
    tsl_pkg::bundle_t  push_bundle;
    logic              pop;
    tsl_pkg::bundle_t  head_bundle;
    logic              empty;
    logic              full;

    assign s_ready   = !full;
    assign in_accept = s_valid && s_ready;

    // Front: byte classification and lexer state.
    tsl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_ch       (s_ch),
        .in_is_end   (s_is_end),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // Queue of token words between front and back.
    tsl_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head_bundle (head_bundle),
        .empty       (empty),
        .full        (full)
    );

    // Back: splits each queue word into result words.
    tsl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_bundle   (head_bundle),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_start_pos   (m_start_pos),
        .m_text_len    (m_text_len),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### hw/rtl/tsl_checker.sv
module tsl_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [7:0]                         s_ch,
    input  logic                               s_is_end,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [4:0]                         m_kind,
    input  logic [tsl_pkg::OUT_POS_BITS-1:0]   m_start_pos,
    input  logic [tsl_pkg::LEN_BITS-1:0]       m_text_len,
    input  logic                               m_last_of_run
);

    // A waiting input word stays valid with its payload unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_ch) && $stable(s_is_end))
        else $error("input word changed while waiting");

    // A stalled result word stays valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_kind) && $stable(m_start_pos)
                                && $stable(m_text_len) && $stable(m_last_of_run))
        else $error("result payload changed while stalled");

    // EOF is empty and always closes the run of its end word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == 5'(tsl_pkg::KIND_EOF) |-> m_text_len == '0 && m_last_of_run)
        else $error("malformed EOF result");

    // Two-character operators always report length two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == 5'(tsl_pkg::KIND_EQ) || m_kind == 5'(tsl_pkg::KIND_NOT_EQ))
        |-> m_text_len == tsl_pkg::LEN_BITS'(2))
        else $error("two-character operator with wrong length");

endmodule

bind token_stream_lexer tsl_checker u_tsl_checker (.*);
